// ===== hw/rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, codes and constants of the peer failure detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pfd_pkg;

    // default table size
    localparam int PEER_COUNT_DEF = 16;

    // fixed field widths
    localparam int SLOT_W = 4;
    localparam int TIME_W = 32;
    localparam int MISS_W = 8;
    localparam int CFG_W  = 32;

    localparam logic [MISS_W-1:0] MISS_MAX      = '1;
    localparam logic [MISS_W-1:0] SUSPECT_RESET = 8'd3;
    localparam logic [TIME_W-1:0] DOWN_RESET    = 32'd5000;

    // request codes
    typedef enum logic [1:0] {
        REQ_ADD     = 2'd0,
        REQ_SUCCESS = 2'd1,
        REQ_FAILURE = 2'd2,
        REQ_QUERY   = 2'd3
    } pfd_req_t;

    // health codes
    typedef enum logic [1:0] {
        HEALTH_UP        = 2'd0,
        HEALTH_SUSPECTED = 2'd1,
        HEALTH_DOWN      = 2'd2
    } pfd_health_t;

    // configuration register indexes
    typedef enum logic {
        CFG_SUSPECT_MISSES = 1'b0,
        CFG_DOWN_AFTER_MS  = 1'b1
    } pfd_cfg_idx_t;

    // one entry of the status memory
    typedef struct packed {
        logic              valid;
        pfd_health_t       health;
        logic [MISS_W-1:0] misses;
    } pfd_status_t;

    // write-back controls from the update logic
    typedef struct packed {
        logic        status_we;
        logic        time_we;
        pfd_status_t status;
    } pfd_wb_t;

    // result of one transaction
    typedef struct packed {
        logic        known;
        pfd_health_t health;
        logic        went_down;
        logic        rejoined;
    } pfd_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfd_ram.sv =====
// ----------------------------------------------------------------------------
// pfd_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/pfd_update.sv =====
// ----------------------------------------------------------------------------
// pfd_update
// Next-entry logic: applies one request to the entry read from the table.
// ----------------------------------------------------------------------------
`default_nettype none

module pfd_update
    import pfd_pkg::*;
(
    input  wire pfd_req_t          req,
    input  wire logic              in_range,
    input  wire pfd_status_t       status,
    input  wire logic [TIME_W-1:0] last_contact,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic [MISS_W-1:0] suspect_misses,
    input  wire logic [TIME_W-1:0] down_after_ms,
    output pfd_wb_t                wb,
    output pfd_result_t            result
);

    logic [MISS_W-1:0] miss_inc;
    logic [TIME_W-1:0] elapsed;

    // saturating miss count and wrapping elapsed time
    assign miss_inc = (status.misses == MISS_MAX) ? status.misses
                                                  : MISS_W'(status.misses + 1'b1);
    assign elapsed  = TIME_W'(now_ms - last_contact);

    // apply the request
    always_comb
    begin
        pfd_health_t h;
        h                = status.health;
        wb.status_we     = 1'b0;
        wb.time_we       = 1'b0;
        wb.status        = status;
        result.went_down = 1'b0;
        result.rejoined  = 1'b0;
        case (req)
            REQ_ADD:
            begin
                wb.status_we     = 1'b1;
                wb.time_we       = 1'b1;
                wb.status.valid  = 1'b1;
                wb.status.health = HEALTH_UP;
                wb.status.misses = '0;
            end
            REQ_SUCCESS:
            begin
                if (status.valid)
                begin
                    result.rejoined  = (status.health == HEALTH_DOWN);
                    wb.status_we     = 1'b1;
                    wb.time_we       = 1'b1;
                    wb.status.health = HEALTH_UP;
                    wb.status.misses = '0;
                end
            end
            REQ_FAILURE:
            begin
                if (status.valid && status.health != HEALTH_DOWN)
                begin
                    if (h == HEALTH_UP && miss_inc >= suspect_misses)
                    begin
                        h = HEALTH_SUSPECTED;
                    end
                    if (h == HEALTH_SUSPECTED && elapsed >= down_after_ms)
                    begin
                        h                = HEALTH_DOWN;
                        result.went_down = 1'b1;
                    end
                    wb.status_we     = 1'b1;
                    wb.status.misses = miss_inc;
                    wb.status.health = h;
                end
            end
            default:
            begin
                // query leaves the entry alone
            end
        endcase

        // slot beyond the table: nothing changes, peer reads as unknown
        if (!in_range)
        begin
            wb.status_we     = 1'b0;
            wb.time_we       = 1'b0;
            result.went_down = 1'b0;
            result.rejoined  = 1'b0;
        end

        result.known  = in_range && wb.status.valid;
        result.health = result.known ? wb.status.health : HEALTH_UP;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/peer_failure_detector.sv =====
// A transaction taken at start is read from the status memory into the update
// stage (stage_valid_reg); its result is then registered and strobed on done.
// One transaction at a time: busy stays high while it is in the update stage,
// set by the status memory's registered read followed by the write-back of the
// same entry. Reset: a clearing pass sweeps the status memory with busy held
// high; configuration writes are taken throughout. Results cannot stall.
// ----------------------------------------------------------------------------
// peer_failure_detector
// Heartbeat failure detector over a table of peers held in block memory.
// ----------------------------------------------------------------------------
`default_nettype none

module peer_failure_detector
    import pfd_pkg::*;
#(
    parameter int PEER_COUNT = PEER_COUNT_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        req_type,
    input  wire logic [SLOT_W-1:0] peer_slot,
    input  wire logic [TIME_W-1:0] now_ms,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data,
    output logic                   done,
    output logic [SLOT_W-1:0]      peer_echo,
    output logic                   known,
    output logic [1:0]             health,
    output logic                   went_down,
    output logic                   rejoined
);

    localparam int IDX_W  = $clog2(PEER_COUNT);
    localparam int STAT_W = $bits(pfd_status_t);

    logic                accept;
    logic                clearing_reg;
    logic [IDX_W-1:0]    clr_idx_reg;
    logic                stage_valid_reg;
    pfd_req_t            stage_req_reg;
    logic [SLOT_W-1:0]   stage_slot_reg;
    logic [TIME_W-1:0]   stage_now_reg;
    logic [MISS_W-1:0]   suspect_misses_reg;
    logic [TIME_W-1:0]   down_after_ms_reg;
    logic                done_reg;
    logic [SLOT_W-1:0]   peer_echo_reg;
    pfd_result_t         result_reg;

    logic [IDX_W-1:0]    stage_idx;
    logic                stage_in_range;
    logic [STAT_W-1:0]   stat_rdata;
    logic [TIME_W-1:0]   time_rdata;
    logic                stat_we;
    logic [IDX_W-1:0]    stat_waddr;
    logic [STAT_W-1:0]   stat_wdata;
    logic                time_we;
    pfd_wb_t             wb;
    pfd_result_t         result;

    // one transaction at a time; the interlock keeps reads off a pending write
    assign busy   = clearing_reg || stage_valid_reg;
    assign accept = start && !busy;

    assign stage_idx      = IDX_W'(stage_slot_reg);
    assign stage_in_range = (32'(stage_slot_reg) < 32'(PEER_COUNT));

    // status memory: valid, health, misses (cleared after reset)
    assign stat_we    = clearing_reg || (stage_valid_reg && wb.status_we);
    assign stat_waddr = clearing_reg ? clr_idx_reg : stage_idx;
    assign stat_wdata = clearing_reg ? '0 : STAT_W'(wb.status);

    pfd_ram #(
        .WIDTH (STAT_W),
        .DEPTH (PEER_COUNT)
    ) u_status_ram (
        .clk   (clk),
        .we    (stat_we),
        .waddr (stat_waddr),
        .wdata (stat_wdata),
        .re    (accept),
        .raddr (IDX_W'(peer_slot)),
        .rdata (stat_rdata)
    );

    // last-contact memory, written only by add and success
    assign time_we = stage_valid_reg && wb.time_we;

    pfd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (PEER_COUNT)
    ) u_time_ram (
        .clk   (clk),
        .we    (time_we),
        .waddr (stage_idx),
        .wdata (stage_now_reg),
        .re    (accept),
        .raddr (IDX_W'(peer_slot)),
        .rdata (time_rdata)
    );

    // read-modify-write of the addressed entry
    pfd_update u_update (
        .req            (stage_req_reg),
        .in_range       (stage_in_range),
        .status         (pfd_status_t'(stat_rdata)),
        .last_contact   (time_rdata),
        .now_ms         (stage_now_reg),
        .suspect_misses (suspect_misses_reg),
        .down_after_ms  (down_after_ms_reg),
        .wb             (wb),
        .result         (result)
    );

    // control state, clearing pass and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg       <= 1'b1;
            clr_idx_reg        <= '0;
            stage_valid_reg    <= 1'b0;
            done_reg           <= 1'b0;
            suspect_misses_reg <= SUSPECT_RESET;
            down_after_ms_reg  <= DOWN_RESET;
        end
        else
        begin
            if (clearing_reg)
            begin
                if (clr_idx_reg == IDX_W'(PEER_COUNT - 1))
                begin
                    clearing_reg <= 1'b0;
                end
                clr_idx_reg <= IDX_W'(clr_idx_reg + 1'b1);
            end
            stage_valid_reg <= accept;
            done_reg        <= stage_valid_reg;
            if (cfg_we)
            begin
                unique case (pfd_cfg_idx_t'(cfg_index))
                    CFG_SUSPECT_MISSES: suspect_misses_reg <= cfg_data[MISS_W-1:0];
                    CFG_DOWN_AFTER_MS:  down_after_ms_reg  <= cfg_data[TIME_W-1:0];
                endcase
            end
        end
    end

    // transaction payload and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_req_reg  <= pfd_req_t'(req_type);
            stage_slot_reg <= peer_slot;
            stage_now_reg  <= now_ms;
        end
        if (stage_valid_reg)
        begin
            peer_echo_reg <= stage_slot_reg;
            result_reg    <= result;
        end
    end

    assign done      = done_reg;
    assign peer_echo = peer_echo_reg;
    assign known     = result_reg.known;
    assign health    = 2'(result_reg.health);
    assign went_down = result_reg.went_down;
    assign rejoined  = result_reg.rejoined;

`ifndef SYNTH
    // a result always follows a transaction in the update stage
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(stage_valid_reg))
        else $error("result without a transaction");

    // interlock: no back-to-back transactions on the same memory
    assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |=> !stage_valid_reg)
        else $error("overlapping read-modify-write");

    // a peer that went down is reported known and down
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && went_down) |-> (known && health == HEALTH_DOWN && !rejoined))
        else $error("went_down with inconsistent health");

    // a rejoined peer is reported known and up
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && rejoined) |-> (known && health == HEALTH_UP))
        else $error("rejoined with inconsistent health");
`endif

endmodule

`default_nettype wire
